FILE: rtl/clt_pkg.sv
// Shared types, token codes and keyword tables for the command line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

  localparam int unsigned MaxTokenLength = 255;
  localparam int unsigned NumKeywords    = 17;
  localparam int unsigned ResDepth       = 4;
  localparam int unsigned ResPtrW        = $clog2(ResDepth);
  localparam int unsigned ResCntW        = $clog2(ResDepth + 1);

  // token kinds
  localparam logic [4:0] KindEol      = 5'd0;
  localparam logic [4:0] KindString   = 5'd1;
  localparam logic [4:0] KindBang     = 5'd2;
  localparam logic [4:0] KindLess     = 5'd3;
  localparam logic [4:0] KindGreater  = 5'd4;
  localparam logic [4:0] KindMinus    = 5'd5;
  localparam logic [4:0] KindPlus     = 5'd6;
  localparam logic [4:0] KindKeyword0 = 5'd7;

  // character codes
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNl      = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharBang    = 8'h21;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharLess    = 8'h3C;
  localparam logic [7:0] CharGreater = 8'h3E;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_COMMENT = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] length;
    logic       last;
  } tok_t;

  // results produced by one character, r0 first
  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } scan_out_t;

  // keyword text, right aligned: first character in the highest used byte
  function automatic logic [55:0] kw_text(input logic [4:0] k);
    logic [55:0] t;
    t = '0;
    case (k)
      5'd0:  t = "list";
      5'd1:  t = "run";
      5'd2:  t = "open";
      5'd3:  t = "close";
      5'd4:  t = "leave";
      5'd5:  t = "quit";
      5'd6:  t = "help";
      5'd7:  t = "get";
      5'd8:  t = "put";
      5'd9:  t = "post";
      5'd10: t = "verbose";
      5'd11: t = "follow";
      5'd12: t = "add";
      5'd13: t = "rm";
      5'd14: t = "delete";
      5'd15: t = "on";
      5'd16: t = "off";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [4:0] k);
    logic [2:0] l;
    l = 3'd0;
    case (k)
      5'd0, 5'd2, 5'd5, 5'd6, 5'd9:         l = 3'd4;
      5'd1, 5'd7, 5'd8, 5'd12, 5'd16:       l = 3'd3;
      5'd3, 5'd4:                           l = 3'd5;
      5'd10:                                l = 3'd7;
      5'd11, 5'd14:                         l = 3'd6;
      5'd13, 5'd15:                         l = 3'd2;
      default:                              l = 3'd0;
    endcase
    return l;
  endfunction

  // character at position p of keyword k; only meaningful for p < kw_len(k)
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] p);
    logic [55:0] t;
    logic [2:0]  idx;
    t   = kw_text(k);
    idx = kw_len(k) - 3'd1 - p;
    return t[idx*8 +: 8];
  endfunction

endpackage

FILE: rtl/clt_scan.sv
// Scanner: mode, word length and keyword candidates, with the per-character decode.
`timescale 1ns / 1ps

module clt_scan #(
  parameter int unsigned MAX_TOKEN_LENGTH = clt_pkg::MaxTokenLength
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          char_i,
  output clt_pkg::scan_out_t  out_o
);
  import clt_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_TOKEN_LENGTH);

  scan_mode_e             mode_q, mode_d;
  logic [NumKeywords-1:0] cand_q, cand_d;
  logic [LenW-1:0]        len_q, len_d;

  logic                   is_end, is_sep, is_hash;
  logic [LenW-1:0]        ext_p;
  logic [NumKeywords-1:0] ext_cand_in, ext_cand;
  logic [LenW-1:0]        ext_len;
  logic [4:0]             word_kind;
  logic [LenW+7:0]        len_wide;
  logic                   start_word;

  assign is_end  = (char_i == CharNul) || (char_i == CharNl);
  assign is_sep  = (char_i == CharSpace) || (char_i == CharTab);
  assign is_hash = (char_i == CharHash);

  // outside a word, any extension is the first character of a new word
  assign start_word = (mode_q != MODE_WORD);

  // word extension by one character; a new word starts from position zero
  assign ext_p       = start_word ? '0 : len_q;
  assign ext_cand_in = start_word ? '1 : cand_q;

  always_comb begin
    for (int k = 0; k < NumKeywords; k++) begin
      ext_cand[k] = ext_cand_in[k]
                    && (ext_p < {{(LenW-3){1'b0}}, kw_len(5'(k))})
                    && (kw_char(5'(k), ext_p[2:0]) == char_i);
    end
  end

  assign ext_len = (ext_p < MaxLen) ? ext_p + LenW'(1) : MaxLen;

  // lowest matching keyword wins
  always_comb begin
    word_kind = KindString;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (cand_q[k] && (len_q == {{(LenW-3){1'b0}}, kw_len(5'(k))})) begin
        word_kind = KindKeyword0 + 5'(k);
      end
    end
  end

  assign len_wide = {8'b0, len_q};

  always_comb begin
    mode_d     = mode_q;
    cand_d     = cand_q;
    len_d      = len_q;
    out_o      = '0;
    case (mode_q)
      MODE_WORD: begin
        if (is_end || is_sep || is_hash) begin
          out_o.r0.kind   = word_kind;
          out_o.r0.length = len_wide[7:0];
          mode_d          = is_hash ? MODE_COMMENT : MODE_BETWEEN;
          if (is_end) begin
            out_o.n         = 2'd2;
            out_o.r1.kind   = KindEol;
            out_o.r1.length = 8'd0;
            out_o.r1.last   = 1'b1;
          end else begin
            out_o.n       = 2'd1;
            out_o.r0.last = 1'b1;
          end
        end else begin
          cand_d = ext_cand;
          len_d  = ext_len;
        end
      end
      MODE_COMMENT: begin
        if (is_end) begin
          out_o.n       = 2'd1;
          out_o.r0.kind = KindEol;
          out_o.r0.last = 1'b1;
          mode_d        = MODE_BETWEEN;
        end
      end
      default: begin
        mode_d = MODE_BETWEEN;
        if (is_end) begin
          out_o.n       = 2'd1;
          out_o.r0.kind = KindEol;
          out_o.r0.last = 1'b1;
        end else if (is_sep) begin
          mode_d = MODE_BETWEEN;
        end else if (is_hash) begin
          mode_d = MODE_COMMENT;
        end else begin
          case (char_i)
            CharBang:    out_o.r0.kind = KindBang;
            CharLess:    out_o.r0.kind = KindLess;
            CharGreater: out_o.r0.kind = KindGreater;
            CharMinus:   out_o.r0.kind = KindMinus;
            CharPlus:    out_o.r0.kind = KindPlus;
            default:     out_o.r0.kind = KindString;
          endcase
          if (out_o.r0.kind == KindString) begin
            mode_d     = MODE_WORD;
            cand_d     = ext_cand;
            len_d      = ext_len;
          end else begin
            out_o.n         = 2'd1;
            out_o.r0.length = 8'd1;
            out_o.r0.last   = 1'b1;
          end
        end
      end
    endcase
    if (!valid_i) begin
      mode_d = mode_q;
      cand_d = cand_q;
      len_d  = len_q;
      out_o  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN;
      cand_q <= '1;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      len_q  <= len_d;
    end
  end

  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.n == 2'd2 |-> out_o.r1.kind == KindEol && out_o.r1.last && !out_o.r0.last)
    else $error("second result must be end of line");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.n == 2'd1 |-> out_o.r0.last)
    else $error("single result not marked last");

  a_keyword_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.n != 2'd0 && out_o.r0.kind >= KindKeyword0) |-> out_o.r0.length <= 8'd7)
    else $error("keyword with impossible length");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |=> $stable(mode_q) && $stable(cand_q) && $stable(len_q))
    else $error("scan state changed without a word");

endmodule

FILE: rtl/clt_resq.sv
// Result queue: takes up to two results a cycle, hands out one per cycle while ready_i is high.
`timescale 1ns / 1ps

module clt_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clt_pkg::scan_out_t push_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output clt_pkg::tok_t      tok_o
);
  import clt_pkg::*;

  tok_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  logic               pop;

  assign valid_o = (count_q != '0);
  assign space_o = (count_q <= ResCntW'(ResDepth - 2));
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem_q[rptr_q];

  assign wptr_d  = wptr_q + ResPtrW'(push_i.n);
  assign rptr_d  = rptr_q + ResPtrW'(pop);
  assign count_d = count_q + ResCntW'(push_i.n) - ResCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wptr_q + ResPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ResCntW'(ResDepth))
    else $error("result queue overfilled");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> count_q + ResCntW'(push_i.n) <= ResCntW'(ResDepth) + ResCntW'(pop))
    else $error("push into full result queue");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + ResCntW'($past(push_i.n)) - ResCntW'($past(pop)))
    else $error("result count out of step");

endmodule

FILE: rtl/command_line_tokenizer.sv
// Top level of the command line tokenizer: stream ports around scanner and result queue.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel s_axis_*: one character word per handshake, byte in tdata[7:0].
//   Master channel m_axis_*: one token per word. tdata[4:0] is the token kind,
//   tdata[12:5] its length (saturated, zero for end of line); tlast marks the
//   final token caused by a character.
//   A token enters the result queue when the character that ends it is taken
//   and is offered on the master side once the tokens ahead of it have drained.
//   Throughput: one character per cycle while s_axis_tready_o is high. Most
//   characters give zero or one token; a word ended by newline or zero gives two,
//   which drain one per cycle while m_axis_tready_i is high. The scanner updates
//   its state in the accepting cycle, so the next character can follow at once.
//   A four-entry result queue decouples the sides: s_axis_tready_o is high while
//   at least two entries are free, so a stalled receiver first fills the queue
//   and then holds off input; nothing is dropped.
//   Reset (rst_ni low, asynchronous) returns to between tokens and empties the
//   queue; a character stream can start in the first cycle after reset.
//
module command_line_tokenizer #(
  parameter int unsigned MAX_TOKEN_LENGTH = clt_pkg::MaxTokenLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [4:0] token_kind, [12:5] token_length, [15:13] zero
  output logic        m_axis_tlast_o
);
  import clt_pkg::*;

  logic      in_fire;
  scan_out_t scan_out;
  tok_t      tok;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  clt_scan #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_fire),
    .char_i (s_axis_tdata_i),
    .out_o  (scan_out)
  );

  clt_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (scan_out),
    .space_o(s_axis_tready_o),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .tok_o  (tok)
  );

  assign m_axis_tdata_o = {3'b000, tok.length, tok.kind};
  assign m_axis_tlast_o = tok.last;

endmodule
